// ===== rtl/csv_line_field_splitter_top_assert.svh =====
// assertion macros for the csv line splitter checker
// expects clk and arst_n in the scope where the macros are used
`ifndef CSV_LINE_FIELD_SPLITTER_TOP_ASSERT_SVH
`define CSV_LINE_FIELD_SPLITTER_TOP_ASSERT_SVH

// same-cycle implication
`define CSVS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csv splitter check failed");

// next-cycle implication
`define CSVS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csv splitter check failed");

`endif

// ===== rtl/csvs_pkg.sv =====
// shared types and constants for the csv line field splitter
// no dependencies
`timescale 1ns / 1ps

package csvs_pkg;

	localparam int DEF_MAX_LINE_BYTES = 4096;
	localparam int CNT_W = 13;
	localparam int BYTE_W = 8;

	localparam logic [BYTE_W-1:0] QUOTE_BYTE = 8'd34;
	localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'd32;

	localparam logic [BYTE_W-1:0] RST_DELIMITER = 8'd44;
	localparam logic [BYTE_W-1:0] RST_ESCAPE = 8'd92;
	localparam logic [CNT_W-1:0] RST_MAX_FIELDS = '0;

	localparam logic [1:0] REG_DELIMITER = 2'd0;
	localparam logic [1:0] REG_ESCAPE = 2'd1;
	localparam logic [1:0] REG_MAX_FIELDS = 2'd2;

	localparam logic [1:0] ST_FIELD_BYTE = 2'd0;
	localparam logic [1:0] ST_LINE_DONE = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;
	localparam logic [1:0] ST_NOT_READY = 2'd3;

	localparam logic [1:0] MODE_BETWEEN = 2'd0;
	localparam logic [1:0] MODE_LITERAL = 2'd1;
	localparam logic [1:0] MODE_QUOTED = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_OPEN, S_L_RD, S_L_CHK, S_Q_RD, S_Q_CHK, S_Q_CHK2,
		S_K_RD, S_K_CHK, S_E_RD, S_E_CHK, S_E_CHK2
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_PUSH, OP_STAT, OP_EMPTY, OP_RD_SCAN, OP_LIT_SCAN, OP_LIT_SCAN1,
		OP_QSTART, OP_RD_PTR, OP_RD_PTR1, OP_LIT_DONE, OP_PTR_INC, OP_PTR_INC2,
		OP_QCLOSE, OP_QSET, OP_RD_CUR, OP_RD_CUR1, OP_EMIT_NOBYTE, OP_EMIT_RD, OP_EMIT_B
	} op_t;

	typedef struct packed {
		op_t op;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic complete;
		logic ovf;
		logic capped;
		logic scan_lt_len;
		logic pend;
		logic mode_zero;
		logic quoted;
		logic ptr_lt_len;
		logic ptr1_lt_len;
		logic cur_lt_end;
		logic cur1_lt_len;
		logic rd_is_quote;
		logic rd_is_delim;
		logic rd_le_space;
		logic b_is_quote;
		logic b_is_esc;
	} flags_t;

endpackage

// ===== rtl/csv_line_field_splitter_top.sv =====
// top level of the csv line field splitter: controller plus datapath
// depends on csvs_pkg, csvs_ctrl, csvs_dp
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  request   | start, busy        | req_type, data_byte, has_byte, last_byte
//  result    | done               | status, out_byte, byte_valid, field_index,
//            |                    | end_of_field, was_quoted
//  config    | wr_en              | wr_index, wr_data
//
// busy stays low through a push beat, so pushes run every cycle while no fetch is busy
// a fetch with no field to decode answers the next cycle; otherwise the field
// opening scan reads and checks the line memory one byte at a time (quoted bytes
// may need a second check) and each result byte is read through the one read port
// reset is asynchronous; no clearing pass; the receiver cannot stall results
`timescale 1ns / 1ps

module csv_line_field_splitter_top
	import csvs_pkg::*;
#(
	parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              req_type,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              has_byte,
	input  logic              last_byte,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [CNT_W-1:0]  wr_data,
	output logic              done,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic [CNT_W-1:0]  field_index,
	output logic              end_of_field,
	output logic              was_quoted
);

	cmd_t   cmd;
	flags_t flags;

	csvs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.flags    (flags),
		.cmd      (cmd),
		.busy     (busy)
	);

	csvs_dp #(
		.MAX_LINE_BYTES (MAX_LINE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.flags        (flags),
		.data_byte    (data_byte),
		.has_byte     (has_byte),
		.last_byte    (last_byte),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.done         (done),
		.status       (status),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.field_index  (field_index),
		.end_of_field (end_of_field),
		.was_quoted   (was_quoted)
	);

endmodule

// ===== rtl/csvs_ctrl.sv =====
// controller state machine for the csv line field splitter
// depends on csvs_pkg
`timescale 1ns / 1ps

module csvs_ctrl
	import csvs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  logic   req_type,
	input  flags_t flags,
	output cmd_t   cmd,
	output logic   busy
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start && req_type && flags.complete && !flags.ovf) begin
					if (flags.mode_zero) begin
						if (!flags.capped && flags.scan_lt_len) state_nx = S_OPEN;
					end else begin
						state_nx = S_E_RD;
					end
				end
			end
			S_OPEN: state_nx = flags.rd_is_quote ? S_Q_RD : S_L_RD;
			S_L_RD: state_nx = flags.ptr_lt_len ? S_L_CHK : S_E_RD;
			S_L_CHK: state_nx = flags.rd_is_delim ? S_E_RD : S_L_RD;
			S_Q_RD: state_nx = flags.ptr_lt_len ? S_Q_CHK : S_L_RD;
			S_Q_CHK: begin
				if (flags.ptr1_lt_len) state_nx = S_Q_CHK2;
				else if (flags.rd_is_quote) state_nx = S_K_RD;
				else state_nx = S_Q_RD;
			end
			S_Q_CHK2: begin
				if (flags.b_is_quote && !flags.rd_is_quote) state_nx = S_K_RD;
				else state_nx = S_Q_RD;
			end
			S_K_RD: state_nx = flags.ptr_lt_len ? S_K_CHK : S_E_RD;
			S_K_CHK: begin
				if (flags.rd_is_delim) state_nx = S_E_RD;
				else if (flags.rd_le_space) state_nx = S_K_RD;
				else state_nx = S_L_RD;
			end
			S_E_RD: state_nx = flags.cur_lt_end ? S_E_CHK : S_IDLE;
			S_E_CHK: state_nx = (flags.quoted && flags.cur1_lt_len) ? S_E_CHK2 : S_IDLE;
			S_E_CHK2: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		cmd.code = ST_FIELD_BYTE;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!req_type) begin
						cmd.op = OP_PUSH;
					end else if (!flags.complete) begin
						cmd.op = OP_STAT;
						cmd.code = ST_NOT_READY;
					end else if (flags.ovf) begin
						cmd.op = OP_STAT;
						cmd.code = ST_TOO_LONG;
					end else if (flags.mode_zero) begin
						if (flags.capped) begin
							cmd.op = OP_STAT;
							cmd.code = ST_LINE_DONE;
						end else if (flags.scan_lt_len) begin
							cmd.op = OP_RD_SCAN;
						end else if (flags.pend) begin
							cmd.op = OP_EMPTY;
						end else begin
							cmd.op = OP_STAT;
							cmd.code = ST_LINE_DONE;
						end
					end
				end
			end
			S_OPEN: cmd.op = flags.rd_is_quote ? OP_QSTART : OP_LIT_SCAN;
			S_L_RD: cmd.op = flags.ptr_lt_len ? OP_RD_PTR : OP_LIT_DONE;
			S_L_CHK: cmd.op = flags.rd_is_delim ? OP_LIT_DONE : OP_PTR_INC;
			S_Q_RD: cmd.op = flags.ptr_lt_len ? OP_RD_PTR : OP_LIT_SCAN1;
			S_Q_CHK: begin
				if (flags.ptr1_lt_len) cmd.op = OP_RD_PTR1;
				else if (flags.rd_is_quote) cmd.op = OP_QCLOSE;
				else cmd.op = OP_PTR_INC;
			end
			S_Q_CHK2: begin
				if ((flags.b_is_esc || flags.b_is_quote) && flags.rd_is_quote) cmd.op = OP_PTR_INC2;
				else if (flags.b_is_quote) cmd.op = OP_QCLOSE;
				else cmd.op = OP_PTR_INC;
			end
			S_K_RD: cmd.op = flags.ptr_lt_len ? OP_RD_PTR : OP_QSET;
			S_K_CHK: begin
				if (flags.rd_is_delim) cmd.op = OP_QSET;
				else if (flags.rd_le_space) cmd.op = OP_PTR_INC;
				else cmd.op = OP_LIT_SCAN;
			end
			S_E_RD: cmd.op = flags.cur_lt_end ? OP_RD_CUR : OP_EMIT_NOBYTE;
			S_E_CHK: cmd.op = (flags.quoted && flags.cur1_lt_len) ? OP_RD_CUR1 : OP_EMIT_RD;
			S_E_CHK2: cmd.op = OP_EMIT_B;
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== rtl/csvs_dp.sv =====
// datapath for the csv line field splitter: line memory, scan registers, results
// depends on csvs_pkg
`timescale 1ns / 1ps

module csvs_dp
	import csvs_pkg::*;
#(
	parameter int MAX_LINE_BYTES = DEF_MAX_LINE_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output flags_t            flags,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              has_byte,
	input  logic              last_byte,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [CNT_W-1:0]  wr_data,
	output logic              done,
	output logic [1:0]        status,
	output logic [BYTE_W-1:0] out_byte,
	output logic              byte_valid,
	output logic [CNT_W-1:0]  field_index,
	output logic              end_of_field,
	output logic              was_quoted
);

	localparam int AW = $clog2(MAX_LINE_BYTES);
	localparam int LW = $clog2(MAX_LINE_BYTES + 1);
	localparam int FCW = (LW + 1 > CNT_W) ? LW + 1 : CNT_W;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_LINE_BYTES);

	logic [BYTE_W-1:0] mem [MAX_LINE_BYTES];
	logic [BYTE_W-1:0] rdata_q;
	logic [AW-1:0]     rd_addr;

	logic [BYTE_W-1:0] delim_q, esc_cfg_q, esc_q, b_q;
	logic [CNT_W-1:0]  maxf_q;

	logic [LW-1:0]  len_q, scan_q, ptr_q, cur_q, fend_q, resume_q;
	logic [FCW-1:0] count_q;
	logic [1:0]     mode_q;
	logic           complete_q, ovf_q, pend_q, took_q;

	logic [LW:0]   ptr_p1, ptr_p2, cur_p1, cur_p2, scan_p1;
	logic [LW-1:0] len_base, new_cur;
	logic [BYTE_W-1:0] res_byte;
	logic          res_valid, eof, push_store, dbl;

	assign ptr_p1  = {1'b0, ptr_q} + 1'b1;
	assign ptr_p2  = {1'b0, ptr_q} + 2'd2;
	assign cur_p1  = {1'b0, cur_q} + 1'b1;
	assign cur_p2  = {1'b0, cur_q} + 2'd2;
	assign scan_p1 = {1'b0, scan_q} + 1'b1;

	assign len_base   = complete_q ? '0 : len_q;
	assign push_store = (cmd.op == OP_PUSH) && has_byte && (len_base < MAX_LEN);

	always_comb begin
		flags.complete    = complete_q;
		flags.ovf         = ovf_q;
		flags.capped      = (maxf_q != '0) && (count_q >= FCW'(maxf_q));
		flags.scan_lt_len = scan_q < len_q;
		flags.pend        = pend_q;
		flags.mode_zero   = (mode_q == MODE_BETWEEN);
		flags.quoted      = (mode_q == MODE_QUOTED);
		flags.ptr_lt_len  = ptr_q < len_q;
		flags.ptr1_lt_len = ptr_p1 < {1'b0, len_q};
		flags.cur_lt_end  = cur_q < fend_q;
		flags.cur1_lt_len = cur_p1 < {1'b0, len_q};
		flags.rd_is_quote = (rdata_q == QUOTE_BYTE);
		flags.rd_is_delim = (rdata_q == delim_q);
		flags.rd_le_space = (rdata_q <= SPACE_BYTE);
		flags.b_is_quote  = (b_q == QUOTE_BYTE);
		flags.b_is_esc    = (esc_q != '0) && (b_q == esc_q);
	end

	always_comb begin
		unique case (cmd.op)
			OP_RD_SCAN: rd_addr = scan_q[AW-1:0];
			OP_RD_PTR1: rd_addr = ptr_p1[AW-1:0];
			OP_RD_CUR:  rd_addr = cur_q[AW-1:0];
			OP_RD_CUR1: rd_addr = cur_p1[AW-1:0];
			default:    rd_addr = ptr_q[AW-1:0];
		endcase
	end

	// line memory
	always_ff @(posedge clk) begin
		if (push_store) mem[len_base[AW-1:0]] <= data_byte;
		rdata_q <= mem[rd_addr];
	end

	// field byte decode
	always_comb begin
		dbl = (flags.b_is_esc || flags.b_is_quote) && flags.rd_is_quote;
		res_byte = '0;
		res_valid = 1'b0;
		new_cur = cur_q;
		unique case (cmd.op)
			OP_EMIT_RD: begin
				res_byte = rdata_q;
				res_valid = 1'b1;
				new_cur = cur_p1[LW-1:0];
			end
			OP_EMIT_B: begin
				res_byte = dbl ? QUOTE_BYTE : b_q;
				res_valid = 1'b1;
				new_cur = dbl ? cur_p2[LW-1:0] : cur_p1[LW-1:0];
			end
			default: begin
				res_byte = '0;
			end
		endcase
		eof = new_cur >= fend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= RST_DELIMITER;
			esc_cfg_q <= RST_ESCAPE;
			maxf_q <= RST_MAX_FIELDS;
		end else if (wr_en) begin
			case (wr_index)
				REG_DELIMITER:  delim_q <= wr_data[BYTE_W-1:0];
				REG_ESCAPE:     esc_cfg_q <= wr_data[BYTE_W-1:0];
				REG_MAX_FIELDS: maxf_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			scan_q <= '0;
			ptr_q <= '0;
			cur_q <= '0;
			fend_q <= '0;
			resume_q <= '0;
			count_q <= '0;
			mode_q <= MODE_BETWEEN;
			complete_q <= 1'b0;
			ovf_q <= 1'b0;
			pend_q <= 1'b0;
			took_q <= 1'b0;
			esc_q <= '0;
			b_q <= '0;
			done <= 1'b0;
			status <= ST_FIELD_BYTE;
			out_byte <= '0;
			byte_valid <= 1'b0;
			field_index <= '0;
			end_of_field <= 1'b0;
			was_quoted <= 1'b0;
		end else begin
			done <= 1'b0;
			status <= ST_FIELD_BYTE;
			out_byte <= '0;
			byte_valid <= 1'b0;
			field_index <= '0;
			end_of_field <= 1'b0;
			was_quoted <= 1'b0;
			unique case (cmd.op)
				OP_PUSH: begin
					if (complete_q) begin
						scan_q <= '0;
						count_q <= '0;
						mode_q <= MODE_BETWEEN;
						fend_q <= '0;
						cur_q <= '0;
						resume_q <= '0;
						took_q <= 1'b0;
						pend_q <= 1'b0;
						complete_q <= 1'b0;
						ovf_q <= 1'b0;
						len_q <= '0;
					end
					if (has_byte) begin
						if (push_store) len_q <= len_base + 1'b1;
						else ovf_q <= 1'b1;
					end
					if (last_byte) begin
						complete_q <= 1'b1;
						pend_q <= (len_base == '0) && !has_byte;
					end
				end
				OP_STAT: begin
					done <= 1'b1;
					status <= cmd.code;
				end
				OP_EMPTY: begin
					done <= 1'b1;
					field_index <= count_q[CNT_W-1:0];
					end_of_field <= 1'b1;
					count_q <= count_q + 1'b1;
					pend_q <= 1'b0;
				end
				OP_RD_SCAN: esc_q <= esc_cfg_q;
				OP_LIT_SCAN: begin
					ptr_q <= scan_q;
					cur_q <= scan_q;
				end
				OP_LIT_SCAN1: begin
					ptr_q <= scan_p1[LW-1:0];
					cur_q <= scan_p1[LW-1:0];
				end
				OP_QSTART: ptr_q <= scan_p1[LW-1:0];
				OP_RD_PTR1: b_q <= rdata_q;
				OP_RD_CUR1: b_q <= rdata_q;
				OP_PTR_INC: ptr_q <= ptr_p1[LW-1:0];
				OP_PTR_INC2: ptr_q <= ptr_p2[LW-1:0];
				OP_QCLOSE: begin
					fend_q <= ptr_q;
					ptr_q <= ptr_p1[LW-1:0];
					cur_q <= scan_p1[LW-1:0];
				end
				OP_LIT_DONE, OP_QSET: begin
					if (cmd.op == OP_QSET) mode_q <= MODE_QUOTED;
					else begin
						mode_q <= MODE_LITERAL;
						fend_q <= ptr_q;
					end
					took_q <= flags.ptr_lt_len;
					resume_q <= flags.ptr_lt_len ? ptr_p1[LW-1:0] : ptr_q;
				end
				OP_EMIT_NOBYTE, OP_EMIT_RD, OP_EMIT_B: begin
					done <= 1'b1;
					out_byte <= res_byte;
					byte_valid <= res_valid;
					field_index <= count_q[CNT_W-1:0];
					end_of_field <= eof;
					was_quoted <= (mode_q == MODE_QUOTED);
					cur_q <= new_cur;
					if (eof) begin
						count_q <= count_q + 1'b1;
						scan_q <= resume_q;
						pend_q <= took_q;
						mode_q <= MODE_BETWEEN;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/csvs_checker.sv =====
// port-level checks for the csv line field splitter, bound to the top level
// depends on csvs_pkg and csv_line_field_splitter_top_assert.svh
`timescale 1ns / 1ps
`include "csv_line_field_splitter_top_assert.svh"

module csvs_checker
	import csvs_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              req_type,
	input logic              done,
	input logic [1:0]        status,
	input logic [BYTE_W-1:0] out_byte,
	input logic              byte_valid,
	input logic [CNT_W-1:0]  field_index,
	input logic              end_of_field,
	input logic              was_quoted
);

	// non-byte answers carry an all-zero payload
	`CSVS_ASSERT_NOW(a_status_payload, done && (status != ST_FIELD_BYTE), out_byte == '0 && !byte_valid && field_index == '0 && !end_of_field && !was_quoted)
	// a push beat never produces a result
	`CSVS_ASSERT_NEXT(a_push_silent, start && !busy && !req_type, !done)
	// a fetch beat is either answered next cycle or keeps the block busy
	`CSVS_ASSERT_NEXT(a_fetch_progress, start && !busy && req_type, busy || done)
	// a result always lands with the controller back at rest
	`CSVS_ASSERT_NOW(a_done_idle, done, !busy)
	// an empty field result ends its field
	`CSVS_ASSERT_NOW(a_empty_ends, done && (status == ST_FIELD_BYTE) && !byte_valid, end_of_field && out_byte == '0)

endmodule

bind csv_line_field_splitter_top csvs_checker u_csvs_checker (.*);

// ===== tb/csv_line_field_splitter_top_tb.sv =====
// testbench for csv_line_field_splitter_top: directed table and cases, then random csv lines
// depends on csvs_pkg and the splitter rtl; self-checking against an inline predictor
`timescale 1ns / 1ps

module csv_line_field_splitter_top_tb;
	import csvs_pkg::*;

	localparam int LINE_CAP = DEF_MAX_LINE_BYTES;
	localparam int STALL_LIMIT = 40000;

	typedef struct packed {
		logic [1:0] st;
		logic [7:0] ob;
		logic bv;
		logic [12:0] fi;
		logic eof;
		logic wq;
	} field_beat_t;

	typedef struct {
		logic rt;
		logic [7:0] db;
		logic hb;
		logic lb;
		logic chk;
		field_beat_t exp;
	} stim_row_t;

	logic clk, arst_n, start, busy, req_type, has_byte, last_byte, wr_en, done;
	logic [7:0] data_byte, out_byte;
	logic [1:0] wr_index, status;
	logic [12:0] wr_data, field_index;
	logic byte_valid, end_of_field, was_quoted;

	csv_line_field_splitter_top dut (.*);

	// predictor state
	logic [7:0] lstore [LINE_CAP];
	int unsigned llen, scanp, fcount, fmode, fend, curp, resp, fesc;
	bit lcomp, lovf, pend, tookd;
	logic [7:0] p_delim, p_esc;
	logic [12:0] p_maxf;

	field_beat_t beat_q [$];
	int errors, stall_cnt;
	bit tail_phase;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_line();
		llen = 0; lcomp = 0; lovf = 0; scanp = 0; fcount = 0; fmode = 0; fend = 0;
		pend = 0; curp = 0; resp = 0; tookd = 0; fesc = 0;
	endfunction

	function automatic void open_literal(int unsigned s);
		int unsigned e;
		e = s;
		while (e < llen && lstore[e] != p_delim) e++;
		fmode = 1; curp = s; fend = e;
		tookd = e < llen;
		resp = tookd ? e + 1 : e;
	endfunction

	function automatic void open_field();
		int unsigned i, j, k;
		bit closed;
		i = scanp; closed = 0;
		fesc = p_esc;
		if (lstore[i] != QUOTE_BYTE) begin
			open_literal(i);
			return;
		end
		j = i + 1;
		while (j < llen) begin
			if (fesc != 0 && lstore[j] == fesc && j + 1 < llen && lstore[j+1] == QUOTE_BYTE)
				j += 2;
			else if (lstore[j] == QUOTE_BYTE) begin
				if (j + 1 < llen && lstore[j+1] == QUOTE_BYTE) j += 2;
				else begin
					closed = 1;
					break;
				end
			end else j++;
		end
		if (!closed) begin
			open_literal(i + 1);
			return;
		end
		k = j + 1;
		while (k < llen && lstore[k] <= SPACE_BYTE && lstore[k] != p_delim) k++;
		if (k == llen || lstore[k] == p_delim) begin
			fmode = 2; curp = i + 1; fend = j;
			tookd = k < llen;
			resp = tookd ? k + 1 : k;
		end else open_literal(i);
	endfunction

	// returns 1 with the expected beat for a fetch, 0 for a push
	function automatic bit predict_beat(logic rt, logic [7:0] db, logic hb, logic lb,
			output field_beat_t r);
		bit q, nq;
		logic [7:0] b;
		r = '0;
		if (!rt) begin
			if (lcomp) clear_line();
			if (hb) begin
				if (llen < LINE_CAP) begin
					lstore[llen] = db;
					llen++;
				end else lovf = 1;
			end
			if (lb) begin
				lcomp = 1;
				pend = (llen == 0);
			end
			return 0;
		end
		if (!lcomp) begin
			r.st = ST_NOT_READY;
			return 1;
		end
		if (lovf) begin
			r.st = ST_TOO_LONG;
			return 1;
		end
		if (fmode == 0) begin
			if (p_maxf != 0 && fcount >= p_maxf) begin
				r.st = ST_LINE_DONE;
				return 1;
			end
			if (scanp < llen) open_field();
			else if (pend) begin
				pend = 0;
				r.st = ST_FIELD_BYTE; r.fi = fcount[12:0]; r.eof = 1;
				fcount++;
				return 1;
			end else begin
				r.st = ST_LINE_DONE;
				return 1;
			end
		end
		q = (fmode == 2);
		if (curp < fend) begin
			r.bv = 1;
			b = lstore[curp];
			nq = curp + 1 < llen && lstore[curp+1] == QUOTE_BYTE;
			if (q && ((fesc != 0 && b == fesc && nq) || (b == QUOTE_BYTE && nq))) begin
				r.ob = QUOTE_BYTE; curp += 2;
			end else begin
				r.ob = b; curp++;
			end
		end
		r.eof = curp >= fend;
		r.st = ST_FIELD_BYTE; r.fi = fcount[12:0]; r.wq = q;
		if (r.eof) begin
			fcount++; scanp = resp; pend = tookd; fmode = 0;
		end
		return 1;
	endfunction

	// result monitor
	always @(posedge clk) begin
		field_beat_t e;
		if (arst_n && done) begin
			if (beat_q.size() == 0) begin
				$error("unexpected result beat status=%0d", status);
				errors++;
			end else begin
				e = beat_q.pop_front();
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); errors++;
				end
				if (out_byte !== e.ob) begin
					$error("out_byte exp %0h got %0h", e.ob, out_byte); errors++;
				end
				if (byte_valid !== e.bv) begin
					$error("byte_valid exp %0d got %0d", e.bv, byte_valid); errors++;
				end
				if (field_index !== e.fi) begin
					$error("field_index exp %0d got %0d", e.fi, field_index); errors++;
				end
				if (end_of_field !== e.eof) begin
					$error("end_of_field exp %0d got %0d", e.eof, end_of_field); errors++;
				end
				if (was_quoted !== e.wq) begin
					$error("was_quoted exp %0d got %0d", e.wq, was_quoted); errors++;
				end
			end
		end
	end

	// watchdog on cycles with nothing accepted and no result
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic idle_gap();
		int n;
		n = $urandom_range(1, 14);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_req(logic rt, logic [7:0] db, logic hb, logic lb, logic chk,
			field_beat_t fixed);
		field_beat_t r;
		bit has;
		start <= 1; req_type <= rt; data_byte <= db; has_byte <= hb; last_byte <= lb;
		@(posedge clk);
		while (busy) @(posedge clk);
		has = predict_beat(rt, db, hb, lb, r);
		if (has) begin
			if (chk && r != fixed) begin
				$error("table row mismatch exp %0h pred %0h", fixed, r); errors++;
			end
			beat_q = {beat_q, r};
		end
		if (!tail_phase && $urandom_range(0, 3) == 0) idle_gap();
	endtask

	task automatic push_byte(logic [7:0] b, logic lb);
		send_req(0, b, 1, lb, 0, '0);
	endtask

	task automatic fetch();
		send_req(1, 8'($urandom), 1'($urandom), 1'($urandom), 0, '0);
	endtask

	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (beat_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		wr_en <= 1; wr_index <= idx; wr_data <= val;
		@(posedge clk);
		wr_en <= 0;
		if (idx == REG_DELIMITER) p_delim = val[7:0];
		else if (idx == REG_ESCAPE) p_esc = val[7:0];
		else p_maxf = val;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1: return QUOTE_BYTE;
			2, 3: return p_delim;
			4: return p_esc;
			5: return SPACE_BYTE;
			6: return 8'($urandom_range(0, 31));
			default: return 8'($urandom);
		endcase
	endfunction

	// random line, then fetch until line done plus a few more
	task automatic random_line(int maxlen);
		int n, f;
		n = $urandom_range(0, maxlen);
		if ($urandom_range(0, 15) == 0) send_req(1, 0, 0, 0, 0, '0);
		if ($urandom_range(0, 15) == 0) send_req(0, 8'($urandom), 0, 0, 0, '0);
		if (n == 0) send_req(0, 8'($urandom), 0, 1, 0, '0);
		for (int i = 0; i < n; i++) push_byte(pick_byte(), i == n - 1);
		f = 0;
		while (f < 3 * n + 8) begin
			fetch();
			f++;
			if (beat_q.size() != 0 && beat_q[$].st == ST_LINE_DONE &&
					$urandom_range(0, 1) == 0)
				break;
		end
	endtask

	stim_row_t dir_tab [$];

	function automatic stim_row_t row(logic rt, logic [7:0] db, logic hb, logic lb,
			logic chk, logic [1:0] st, logic [7:0] ob, logic bv, logic [12:0] fi,
			logic eof, logic wq);
		stim_row_t s;
		s.rt = rt; s.db = db; s.hb = hb; s.lb = lb; s.chk = chk;
		s.exp = '{st, ob, bv, fi, eof, wq};
		return s;
	endfunction

	initial begin
		errors = 0; tail_phase = 0;
		arst_n = 0; start = 0; req_type = 0; data_byte = 0; has_byte = 0;
		last_byte = 0; wr_en = 0; wr_index = REG_DELIMITER; wr_data = 0;
		p_delim = RST_DELIMITER; p_esc = RST_ESCAPE; p_maxf = RST_MAX_FIELDS;
		clear_line();
		for (int i = 0; i < LINE_CAP; i++) lstore[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: not ready, empty line, extremes, quoting cases
		dir_tab = {dir_tab, row(1, 0, 0, 0, 1, ST_NOT_READY, 0, 0, 0, 0, 0)};
		dir_tab = {dir_tab, row(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0)};
		dir_tab = {dir_tab, row(1, 0, 0, 0, 1, ST_FIELD_BYTE, 0, 0, 0, 1, 0)};
		dir_tab = {dir_tab, row(1, 0, 0, 0, 1, ST_LINE_DONE, 0, 0, 0, 0, 0)};
		dir_tab = {dir_tab, row(0, 8'hff, 1, 0, 0, 0, 0, 0, 0, 0, 0)};
		dir_tab = {dir_tab, row(0, 8'h00, 1, 0, 0, 0, 0, 0, 0, 0, 0)};
		dir_tab = {dir_tab, row(0, 8'h2c, 1, 1, 0, 0, 0, 0, 0, 0, 0)};
		dir_tab = {dir_tab, row(1, 0, 0, 0, 1, ST_FIELD_BYTE, 8'hff, 1, 0, 0, 0)};
		dir_tab = {dir_tab, row(1, 0, 0, 0, 1, ST_FIELD_BYTE, 8'h00, 1, 0, 1, 0)};
		dir_tab = {dir_tab, row(1, 0, 0, 0, 1, ST_FIELD_BYTE, 0, 0, 1, 1, 0)};
		dir_tab = {dir_tab, row(1, 0, 0, 0, 1, ST_LINE_DONE, 0, 0, 0, 0, 0)};
		for (int i = 0; i < dir_tab.size(); i++)
			send_req(dir_tab[i].rt, dir_tab[i].db, dir_tab[i].hb, dir_tab[i].lb,
				dir_tab[i].chk, dir_tab[i].exp);
		// "a\"""b" , then junk after close, unclosed quote
		begin
			string s;
			s = "\"a\\\"\"\"b\" ,\"x\"y,\"z";
			for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
			repeat (12) fetch();
		end
		drain();

		// overlong line
		for (int i = 0; i <= LINE_CAP; i++) push_byte(8'($urandom), i == LINE_CAP);
		send_req(1, 0, 0, 0, 1, '{ST_TOO_LONG, 8'h0, 1'b0, 13'h0, 1'b0, 1'b0});
		drain();

		// sweep register settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin write_reg(REG_DELIMITER, 13'h000); write_reg(REG_ESCAPE, 13'h000);
					write_reg(REG_MAX_FIELDS, 13'd1); end
				1: begin write_reg(REG_DELIMITER, 13'h0ff); write_reg(REG_ESCAPE, 13'h0ff);
					write_reg(REG_MAX_FIELDS, 13'h1fff); end
				2: begin write_reg(REG_DELIMITER, 13'h03b); write_reg(REG_ESCAPE, 13'h022);
					write_reg(REG_MAX_FIELDS, 13'd2); end
				3: begin write_reg(REG_DELIMITER, 13'(SPACE_BYTE));
					write_reg(REG_ESCAPE, 13'h05c); write_reg(REG_MAX_FIELDS, 13'd0); end
				default: begin write_reg(REG_DELIMITER, 13'($urandom_range(0, 255)));
					write_reg(REG_ESCAPE, 13'(($urandom_range(0, 2) == 0) ? 0 :
						$urandom_range(0, 255)));
					write_reg(REG_MAX_FIELDS, 13'($urandom_range(0, 4))); end
			endcase
			if (ph == 7) tail_phase = 1;
			for (int l = 0; l < 10; l++) random_line(12);
			drain();
		end
		write_reg(REG_DELIMITER, 13'(RST_DELIMITER));
		write_reg(REG_ESCAPE, 13'(RST_ESCAPE));
		write_reg(REG_MAX_FIELDS, RST_MAX_FIELDS);
		for (int l = 0; l < 10; l++) random_line(12);
		drain();

		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/csvs_pkg.sv
rtl/csvs_ctrl.sv
rtl/csvs_dp.sv
rtl/csv_line_field_splitter_top.sv
rtl/csvs_checker.sv
tb/csv_line_field_splitter_top_tb.sv
